// File: design/rvw_pkg.sv
// Shared types and constants for the ray voxel walker.
package rvw_pkg;

	localparam int MAX_CELLS = 64;
	localparam int CELL_W = $clog2(MAX_CELLS + 1);
	localparam int COORD_W = 32;
	localparam int REL_W = COORD_W + 1;
	localparam int IDX_W = COORD_W + 2;
	localparam int NUM_W = 32;
	localparam int HALF_W = IDX_W / 2;
	localparam int MUL_W = NUM_W + HALF_W;
	localparam int PROD_W = 73;
	localparam int LEN_W = 16;
	localparam int MUL_STEPS = 12;
	localparam int MCNT_W = 4;

	localparam logic [1:0] REG_ORIGIN_X = 2'd0;
	localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
	localparam logic [1:0] REG_ORIGIN_Z = 2'd2;
	localparam logic [1:0] REG_VOXEL_SHIFT = 2'd3;

	typedef struct packed {
		logic [19:0]        ray_index;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] start_z;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [31:0] end_z;
	} in_word_t;

	typedef struct packed {
		logic [19:0]        ray_tag;
		logic signed [15:0] cell_x;
		logic signed [15:0] cell_y;
		logic signed [15:0] cell_z;
		logic               last;
		logic               truncated;
	} out_word_t;

	typedef struct packed {
		logic              load_in;
		logic              setup;
		logic              mul_run;
		logic              mul_issue;
		logic [MCNT_W-1:0] mul_step;
		logic              emit;
		logic              cap;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic stop;
	} dp_stat_t;

endpackage

// File: design/rvw_ctrl.sv
// Controller: sequences load, setup, product build and the cell walk.
module rvw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rvw_pkg::dp_stat_t stat,
	output rvw_pkg::ctl_cmd_t cmd
);
	import rvw_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SETUP = 4'b0010,
		S_MUL   = 4'b0100,
		S_WALK  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [MCNT_W-1:0] mcnt_q;
	logic [CELL_W-1:0] cells_q;
	logic              final_cell;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load_in = in_valid && (state_q == S_IDLE);
		cmd.setup = (state_q == S_SETUP);
		cmd.mul_run = (state_q == S_MUL);
		cmd.mul_issue = (state_q == S_MUL) && (mcnt_q < MCNT_W'(MUL_STEPS));
		cmd.mul_step = mcnt_q;
		cmd.emit = (state_q == S_WALK) && stat.out_free;
		cmd.cap = (cells_q == CELL_W'(MAX_CELLS - 1));
	end

	assign final_cell = stat.stop || cmd.cap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mcnt_q <= '0;
			cells_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load_in) state_q <= S_SETUP;
				end
				S_SETUP: begin
					mcnt_q <= '0;
					cells_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					mcnt_q <= mcnt_q + 1'b1;
					// last partial product lands as we leave
					if (mcnt_q == MCNT_W'(MUL_STEPS)) state_q <= S_WALK;
				end
				S_WALK: begin
					if (cmd.emit) begin
						cells_q <= cells_q + 1'b1;
						if (final_cell) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: design/rvw_datapath.sv
// Datapath: config registers, cell setup, cross products, stepping and output word.
module rvw_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  rvw_pkg::in_word_t  in_data,
	output rvw_pkg::out_word_t out_data,
	output logic               out_valid,
	input  logic               out_ready,
	input  rvw_pkg::ctl_cmd_t  cmd,
	output rvw_pkg::dp_stat_t  stat
);
	import rvw_pkg::*;

	logic signed [COORD_W-1:0] org_q [3];
	logic [4:0]                vsh_q;
	logic [19:0]               tag_q;
	logic signed [REL_W-1:0]   srel_q [3];
	logic signed [REL_W-1:0]   erel_q [3];
	logic signed [REL_W-1:0]   cs_q [3];
	logic signed [REL_W-1:0]   ce_q [3];
	logic signed [IDX_W-1:0]   idx_q [3];
	logic [IDX_W-1:0]          den_q [3];
	logic [NUM_W-1:0]          num_q [3];
	logic                      pos_q [3];
	logic                      nz_q [3];
	logic [PROD_W-1:0]         p_q [6];
	logic [LEN_W-1:0]          len2_q;
	logic [MUL_W-1:0]          mul_s1;
	logic [2:0]                tgt_s1;
	logic                      hi_s1;
	logic                      vld_s1;
	out_word_t                 out_q;
	logic                      out_valid_q;

	logic signed [COORD_W-1:0] st [3];
	logic signed [COORD_W-1:0] en [3];
	logic [2:0]                pair;
	logic [1:0]                nsel;
	logic [1:0]                dsel;
	logic [NUM_W-1:0]          mul_a;
	logic [HALF_W-1:0]         mul_b;
	logic [PROD_W-1:0]         inc [3];
	logic                      e_xy, e_xz, e_yx, e_yz;
	logic [2:0]                mv;
	logic [LEN_W-1:0]          dist_c;
	logic                      at_end;
	logic [LEN_W-1:0]          len_c;

	function automatic logic [13:0] sq7(input logic [6:0] v);
		return {7'd0, v} * {7'd0, v};
	endfunction

	function automatic logic [6:0] mag7(input logic signed [IDX_W-1:0] v);
		logic [IDX_W-1:0] m;
		m = v[IDX_W-1] ? IDX_W'(-v) : IDX_W'(v);
		return (m > IDX_W'(127)) ? 7'd127 : m[6:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [IDX_W-1:0] v);
		if (v > IDX_W'(32767)) return 16'sh7fff;
		if (v < -IDX_W'(32768)) return -16'sh8000;
		return v[15:0];
	endfunction

	assign st[0] = in_data.start_x;
	assign st[1] = in_data.start_y;
	assign st[2] = in_data.start_z;
	assign en[0] = in_data.end_x;
	assign en[1] = in_data.end_y;
	assign en[2] = in_data.end_z;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q[0] <= '0;
			org_q[1] <= '0;
			org_q[2] <= '0;
			vsh_q <= 5'd16;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ORIGIN_X:    org_q[0] <= cfg_data;
				REG_ORIGIN_Y:    org_q[1] <= cfg_data;
				REG_ORIGIN_Z:    org_q[2] <= cfg_data;
				REG_VOXEL_SHIFT: vsh_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// input load, per-axis setup, walk length and cell stepping
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			tag_q <= in_data.ray_index;
			for (int k = 0; k < 3; k++) begin
				srel_q[k] <= REL_W'(st[k]) - REL_W'(org_q[k]);
				erel_q[k] <= REL_W'(en[k]) - REL_W'(org_q[k]);
			end
		end
		if (cmd.setup) begin
			for (int k = 0; k < 3; k++) begin
				logic signed [REL_W-1:0] c;
				logic signed [IDX_W-1:0] d;
				logic [30:0]             r;
				logic [NUM_W-1:0]        one;
				c = srel_q[k] >>> vsh_q;
				d = IDX_W'(erel_q[k]) - IDX_W'(srel_q[k]);
				r = srel_q[k][30:0] & ((31'd1 << vsh_q) - 31'd1);
				one = NUM_W'(1) << vsh_q;
				cs_q[k] <= c;
				ce_q[k] <= erel_q[k] >>> vsh_q;
				idx_q[k] <= IDX_W'(c);
				pos_q[k] <= !d[IDX_W-1] && (d != '0);
				nz_q[k] <= (d != '0);
				den_q[k] <= d[IDX_W-1] ? IDX_W'(-d) : IDX_W'(d);
				if (d == '0) num_q[k] <= '0;
				else if (!d[IDX_W-1]) num_q[k] <= one - {1'b0, r};
				else num_q[k] <= {1'b0, r};
			end
		end
		if (cmd.mul_run) len2_q <= len_c;
		if (cmd.emit) begin
			for (int k = 0; k < 3; k++) begin
				if (mv[k]) idx_q[k] <= pos_q[k] ? idx_q[k] + 1'b1 : idx_q[k] - 1'b1;
			end
		end
	end

	always_comb begin
		len_c = '0;
		for (int k = 0; k < 3; k++)
			len_c = len_c + LEN_W'(sq7(mag7(IDX_W'(ce_q[k]) - IDX_W'(cs_q[k]))));
	end

	// pair order: xy yx xz zx yz zy, low half then high half of den
	assign pair = cmd.mul_step[3:1];
	always_comb begin
		case (pair)
			3'd0: begin nsel = 2'd0; dsel = 2'd1; end
			3'd1: begin nsel = 2'd1; dsel = 2'd0; end
			3'd2: begin nsel = 2'd0; dsel = 2'd2; end
			3'd3: begin nsel = 2'd2; dsel = 2'd0; end
			3'd4: begin nsel = 2'd1; dsel = 2'd2; end
			default: begin nsel = 2'd2; dsel = 2'd1; end
		endcase
		mul_a = num_q[nsel];
		mul_b = cmd.mul_step[0] ? den_q[dsel][IDX_W-1:HALF_W] : den_q[dsel][HALF_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= cmd.mul_issue;
	end

	always_ff @(posedge clk) begin
		mul_s1 <= MUL_W'(mul_a) * MUL_W'(mul_b);
		tgt_s1 <= pair;
		hi_s1 <= cmd.mul_step[0];
	end

	for (genvar k = 0; k < 3; k++) begin : g_inc
		assign inc[k] = PROD_W'(den_q[k]) << vsh_q;
	end

	// ray-time compare: a before b when num_a*den_b < num_b*den_a
	assign e_xy = nz_q[0] && (!nz_q[1] || p_q[0] < p_q[1]);
	assign e_xz = nz_q[0] && (!nz_q[2] || p_q[2] < p_q[3]);
	assign e_yx = nz_q[1] && (!nz_q[0] || p_q[1] < p_q[0]);
	assign e_yz = nz_q[1] && (!nz_q[2] || p_q[4] < p_q[5]);

	always_comb begin
		mv = '0;
		if (e_xy && e_xz) mv[0] = 1'b1;
		else if (e_yx && e_yz) mv[1] = nz_q[1];
		else if (nz_q[2]) mv[2] = 1'b1;
		else mv[1] = nz_q[1];
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			if (hi_s1) p_q[tgt_s1] <= p_q[tgt_s1] + (PROD_W'(mul_s1) << HALF_W);
			else p_q[tgt_s1] <= PROD_W'(mul_s1);
		end else if (cmd.emit) begin
			if (mv[0]) begin
				p_q[0] <= p_q[0] + inc[1];
				p_q[2] <= p_q[2] + inc[2];
			end
			if (mv[1]) begin
				p_q[1] <= p_q[1] + inc[0];
				p_q[4] <= p_q[4] + inc[2];
			end
			if (mv[2]) begin
				p_q[3] <= p_q[3] + inc[0];
				p_q[5] <= p_q[5] + inc[1];
			end
		end
	end

	// stop test on the current cell
	always_comb begin
		dist_c = '0;
		for (int k = 0; k < 3; k++)
			dist_c = dist_c + LEN_W'(sq7(mag7(idx_q[k] - IDX_W'(cs_q[k]))));
	end
	assign at_end = (idx_q[0] == IDX_W'(ce_q[0])) && (idx_q[1] == IDX_W'(ce_q[1]))
		&& (idx_q[2] == IDX_W'(ce_q[2]));
	assign stat.stop = at_end || (dist_c > len2_q);
	assign stat.out_free = !out_valid_q || out_ready;

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.ray_tag <= tag_q;
			out_q.cell_x <= sat16(idx_q[0]);
			out_q.cell_y <= sat16(idx_q[1]);
			out_q.cell_z <= sat16(idx_q[2]);
			out_q.last <= stat.stop || cmd.cap;
			out_q.truncated <= !stat.stop && cmd.cap;
		end
	end

	assign out_data = out_q;
	assign out_valid = out_valid_q;
endmodule

// File: design/ray_voxel_walker_unit.sv
// Ray voxel walker: one ray in, its crossed voxel cells out in order, up to 64 per ray.
// A ray is accepted only while idle; setup and a twelve-step product build come before its first cell word.
// Throughput: one cell word per cycle while the walk runs and the receiver is ready;
// a new ray is taken only after the last cell word of the previous ray is emitted.
// Reset: arst_n clears control state; origins reset to zero, voxel shift to 16.
module ray_voxel_walker_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rvw_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rvw_pkg::out_word_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import rvw_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	rvw_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat(stat),
		.cmd(cmd)
	);

	rvw_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_data(in_data),
		.out_data(out_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd(cmd),
		.stat(stat)
	);
endmodule

// File: sim/testbench.sv
// Self-checking testbench for the ray voxel walker: directed rays, then random rays.
module testbench;
	import rvw_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		in_word_t  w;
		bit        typed;
		out_word_t want;
	} ray_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_word_t   in_data;
	logic       out_valid;
	logic       out_ready;
	out_word_t  out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	ray_voxel_walker_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// model copy of the grid registers
	longint org_m[3];
	int     shift_m;

	out_word_t cells_due[$];
	int  errors = 0;
	int  rays_sent = 0;
	int  cells_seen = 0;
	int  cycles = 0;
	bit  quiet = 0;
	logic signed [127:0] tnum[3];
	logic signed [127:0] tden[3];
	ray_row_t rows[10];

	initial clk = 0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic longint dist_sq(input longint a[3], input longint b[3]);
		longint s;
		longint m;
		s = 0;
		for (int k = 0; k < 3; k++) begin
			m = a[k] - b[k];
			if (m < 0)
				m = -m;
			if (m > 1048576)
				m = 1048576;
			s += m * m;
		end
		return s;
	endfunction

	function automatic logic [15:0] clamp16(input longint v);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	// axis a meets its next boundary strictly sooner than axis b
	function automatic bit sooner(input int a, input int b);
		if (tden[a] == 0)
			return 0;
		if (tden[b] == 0)
			return 1;
		return (tnum[a] * tden[b]) < (tnum[b] * tden[a]);
	endfunction

	function automatic void walk_ray(input in_word_t r);
		longint srel[3], erel[3], cs[3], ce[3], idx[3], sgn[3];
		longint sp[3], ep[3];
		longint len2, dir, bcell;
		out_word_t c;
		bit stop;
		int n;
		sp[0] = r.start_x; sp[1] = r.start_y; sp[2] = r.start_z;
		ep[0] = r.end_x;   ep[1] = r.end_y;   ep[2] = r.end_z;
		for (int k = 0; k < 3; k++) begin
			srel[k] = sp[k] - org_m[k];
			erel[k] = ep[k] - org_m[k];
			cs[k] = srel[k] >>> shift_m;
			ce[k] = erel[k] >>> shift_m;
			idx[k] = cs[k];
			dir = erel[k] - srel[k];
			sgn[k] = dir > 0 ? 1 : (dir < 0 ? -1 : 0);
			tden[k] = dir < 0 ? -dir : dir;
		end
		len2 = dist_sq(ce, cs);
		n = 0;
		forever begin
			stop = (idx[0] == ce[0] && idx[1] == ce[1] && idx[2] == ce[2]) ||
				dist_sq(idx, cs) > len2;
			c.ray_tag = r.ray_index;
			c.cell_x = clamp16(idx[0]);
			c.cell_y = clamp16(idx[1]);
			c.cell_z = clamp16(idx[2]);
			c.last = 0;
			c.truncated = 0;
			n++;
			if (stop) begin
				c.last = 1;
				cells_due = {cells_due, c};
				break;
			end
			if (n >= MAX_CELLS) begin
				c.last = 1;
				c.truncated = 1;
				cells_due = {cells_due, c};
				break;
			end
			cells_due = {cells_due, c};
			for (int k = 0; k < 3; k++) begin
				bcell = idx[k] + (sgn[k] > 0 ? 1 : 0);
				tnum[k] = ((bcell <<< shift_m) - srel[k]) * sgn[k];
			end
			// ties fall to z, or to y when z is still
			if (sooner(0, 1) && sooner(0, 2))
				idx[0] += sgn[0];
			else if (sooner(1, 0) && sooner(1, 2))
				idx[1] += sgn[1];
			else if (tden[2] != 0)
				idx[2] += sgn[2];
			else
				idx[1] += sgn[1];
		end
	endfunction

	// compare every accepted cell word with the oldest one due
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && out_valid && out_ready) begin
			cells_seen++;
			if (cells_due.size() == 0) begin
				$error("unexpected cell word %p", out_data);
				errors++;
			end else begin
				e = cells_due.pop_front();
				if (out_data.ray_tag !== e.ray_tag) begin
					$error("ray_tag expected %0h got %0h", e.ray_tag, out_data.ray_tag);
					errors++;
				end
				if (out_data.cell_x !== e.cell_x) begin
					$error("cell_x expected %0d got %0d", e.cell_x, out_data.cell_x);
					errors++;
				end
				if (out_data.cell_y !== e.cell_y) begin
					$error("cell_y expected %0d got %0d", e.cell_y, out_data.cell_y);
					errors++;
				end
				if (out_data.cell_z !== e.cell_z) begin
					$error("cell_z expected %0d got %0d", e.cell_z, out_data.cell_z);
					errors++;
				end
				if (out_data.last !== e.last) begin
					$error("last expected %0b got %0b", e.last, out_data.last);
					errors++;
				end
				if (out_data.truncated !== e.truncated) begin
					$error("truncated expected %0b got %0b", e.truncated, out_data.truncated);
					errors++;
				end
			end
		end
	end

	// receiver back-pressure in bursts
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 14);
				out_ready <= 0;
				repeat (n - 1) @(negedge clk);
			end else begin
				out_ready <= 1;
			end
		end
	end

	task automatic send_ray(input in_word_t w, input bit typed, input out_word_t want);
		int n;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 14);
			@(negedge clk);
			in_valid <= 0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		if (typed)
			cells_due = {cells_due, want};
		else
			walk_ray(w);
		rays_sent++;
	endtask

	task automatic drain();
		while (cells_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] i, input logic [31:0] v);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= i;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		if (i == REG_VOXEL_SHIFT)
			shift_m = v[4:0];
		else
			org_m[i] = longint'(signed'(v));
	endtask

	// idle the unit, then load a fresh grid
	task automatic set_grid(input logic [31:0] ox, input logic [31:0] oy,
		input logic [31:0] oz, input logic [4:0] sh);
		@(negedge clk);
		in_valid <= 0;
		drain();
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_ORIGIN_Z, oz);
		write_reg(REG_VOXEL_SHIFT, {27'd0, sh});
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	function automatic in_word_t make_ray();
		in_word_t w;
		longint st, off;
		int kind;
		kind = $urandom_range(0, 9);
		w.ray_index = 20'($urandom);
		w.start_x = $urandom;
		w.start_y = $urandom;
		w.start_z = $urandom;
		w.end_x = $urandom;
		w.end_y = $urandom;
		w.end_z = $urandom;
		if (kind == 0) begin
			w.end_x = w.start_x; w.end_y = w.start_y; w.end_z = w.start_z;
		end else if (kind > 1) begin
			// short ray: a few cells on each axis
			for (int k = 0; k < 3; k++) begin
				off = ((longint'($urandom_range(0, 6)) - 3) <<< shift_m) +
					($urandom & ((longint'(1) <<< shift_m) - 1));
				if ($urandom_range(0, 3) == 0)
					off = 0;
				case (k)
					0: begin st = w.start_x; w.end_x = 32'(st + off); end
					1: begin st = w.start_y; w.end_y = 32'(st + off); end
					default: begin st = w.start_z; w.end_z = 32'(st + off); end
				endcase
			end
		end
		return w;
	endfunction

	task automatic random_rays(input int n);
		out_word_t none;
		none = '0;
		repeat (n)
			send_ray(make_ray(), 0, none);
	endtask

	initial begin
		out_word_t none;
		none = '0;
		in_valid = 0;
		in_data = '0;
		out_ready = 0;
		cfg_valid = 0;
		cfg_index = REG_ORIGIN_X;
		cfg_data = '0;
		org_m[0] = 0; org_m[1] = 0; org_m[2] = 0;
		shift_m = 16;
		arst_n = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// degenerate ray at zero, then the coordinate extremes
		rows[0] = '{'{20'h1, 0, 0, 0, 0, 0, 0}, 1, '{20'h1, 0, 0, 0, 1, 0}};
		rows[1] = '{'{20'h2, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}, 1,
			'{20'h2, 16'sd32767, 16'sd32767, 16'sd32767, 1, 0}};
		rows[2] = '{'{20'h3, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000}, 1,
			'{20'h3, -16'sd32768, -16'sd32768, -16'sd32768, 1, 0}};
		rows[3] = '{'{20'h4, 32'h8000, 32'h8000, 32'h8000, 32'h58000, 32'h8000, 32'h8000},
			0, none};
		rows[4] = '{'{20'h5, 32'h8000, 32'h48000, 32'h8000, 32'h8000, -32'sh38000, 32'h8000},
			0, none};
		// equal ray times on all three axes
		rows[5] = '{'{20'h6, 32'h8000, 32'h8000, 32'h8000, 32'h38000, 32'h38000, 32'h38000},
			0, none};
		// x and y tie with z still
		rows[6] = '{'{20'h7, 32'h8000, 32'h8000, 32'h8000, 32'h38000, 32'h38000, 32'h8000},
			0, none};
		// long enough to hit the cell cap
		rows[7] = '{'{20'h8, 0, 0, 0, 32'h640000, 0, 0}, 0, none};
		rows[8] = '{'{20'hFFFFF, 32'h10000, 32'h30000, -32'sh20000,
			-32'sh50000, 32'h70000, 32'h28000}, 0, none};
		rows[9] = '{'{20'h0, -32'sh8000, 32'h4000, 32'h0, 32'h2C000, -32'sh1C000, 32'h3A000},
			0, none};
		foreach (rows[i])
			send_ray(rows[i].w, rows[i].typed, rows[i].want);
		random_rays(10);

		set_grid($urandom, $urandom, $urandom, 5'd0);
		random_rays(12);
		// hold the sender until every cell so far has come out
		@(negedge clk);
		in_valid <= 0;
		drain();
		random_rays(12);

		set_grid(32'h80000000, 32'h7FFFFFFF, $urandom, 5'd31);
		random_rays(20);

		set_grid($urandom, $urandom, $urandom, 5'($urandom_range(0, 20)));
		random_rays(20);

		// stop idling before the drain so the receiver is ready throughout
		quiet = 1;
		set_grid(32'h7FFFFFFF, 32'h80000000, 32'h0, 5'd16);
		random_rays(20);

		@(negedge clk);
		in_valid <= 0;
		drain();
		$display("Sent %0d rays, checked %0d cell words over five grid settings.",
			rays_sent, cells_seen);
		$display("Grids covered voxel shifts 0, 16, 31 and a random one, origins at extremes.");
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
